// File: hw/rtl/pcbb_pkg.sv
// ----------------------------------------------------------------------------
// pcbb_pkg: shared types and constants for the press counter with blink-back
// Register indexes, reset values, field widths and the structs passed
// between the register block and the core.
// ----------------------------------------------------------------------------
package pcbb_pkg;

    // field widths
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int NOW_W      = 32;
    localparam int COUNT_W    = 7;
    localparam int TOGGLE_W   = 8;

    // default timestamp width
    localparam int TIME_BITS_DEFAULT = 32;

    // saturation limit of the press count
    localparam logic [COUNT_W-1:0] PRESS_MAX = 7'd127;

    // register reset values
    localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd30;
    localparam logic [CFG_W-1:0] IDLE_RESET     = 16'd1000;
    localparam logic [CFG_W-1:0] BLINK_RESET    = 16'd200;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK    = 2'd2;

    // timing registers as seen by the core
    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] idle_ms;
        logic [CFG_W-1:0] blink_ms;
    } cfg_t;

    // one result item
    typedef struct packed {
        logic               red_led;
        logic               blue_led;
        logic [COUNT_W-1:0] presses_pending;
        logic               blinking;
    } result_t;

endpackage

// File: hw/rtl/pcbb_cfg_regs.sv
// ----------------------------------------------------------------------------
// pcbb_cfg_regs: timing register block
// Holds debounce, idle and blink periods; writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module pcbb_cfg_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [pcbb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pcbb_pkg::CFG_W-1:0]     cfg_data,
    output pcbb_pkg::cfg_t                 cfg
);

    pcbb_pkg::cfg_t cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms <= pcbb_pkg::DEBOUNCE_RESET;
            cfg_reg.idle_ms     <= pcbb_pkg::IDLE_RESET;
            cfg_reg.blink_ms    <= pcbb_pkg::BLINK_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                pcbb_pkg::REG_DEBOUNCE: cfg_reg.debounce_ms <= cfg_data;
                pcbb_pkg::REG_IDLE:     cfg_reg.idle_ms     <= cfg_data;
                pcbb_pkg::REG_BLINK:    cfg_reg.blink_ms    <= cfg_data;
                default:                cfg_reg             <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hw/rtl/pcbb_core.sv
// ----------------------------------------------------------------------------
// pcbb_core: press counting and blink sequencing
// Holds the button and LED state and works out one poll per step.
// ----------------------------------------------------------------------------
module pcbb_core
#(
    parameter int TIME_BITS = pcbb_pkg::TIME_BITS_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [TIME_BITS-1:0] now,
    input  logic                 btn,
    input  pcbb_pkg::cfg_t       cfg,
    output pcbb_pkg::result_t    result
);

    // compare width covers both ages and 16-bit periods
    localparam int CMP_W = (TIME_BITS > pcbb_pkg::CFG_W) ? TIME_BITS : pcbb_pkg::CFG_W;

    logic                          level_now_reg;
    logic                          level_before_reg;
    logic                          edge_seen_reg;
    logic [TIME_BITS-1:0]          press_stamp_reg;
    logic [TIME_BITS-1:0]          release_stamp_reg;
    logic [pcbb_pkg::COUNT_W-1:0]  press_total_reg;
    logic                          button_live_reg;
    logic                          lamp_on_reg;
    logic [TIME_BITS-1:0]          lamp_on_stamp_reg;
    logic [TIME_BITS-1:0]          lamp_off_stamp_reg;
    logic [pcbb_pkg::TOGGLE_W-1:0] toggles_left_reg;
    logic                          blink_active_reg;

    logic                          level_before_next;
    logic                          edge_seen_next;
    logic [TIME_BITS-1:0]          press_stamp_next;
    logic [TIME_BITS-1:0]          release_stamp_next;
    logic [pcbb_pkg::COUNT_W-1:0]  press_total_next;
    logic                          button_live_next;
    logic                          lamp_on_next;
    logic [TIME_BITS-1:0]          lamp_on_stamp_next;
    logic [TIME_BITS-1:0]          lamp_off_stamp_next;
    logic [pcbb_pkg::TOGGLE_W-1:0] toggles_left_next;
    logic                          blink_active_next;

    logic [TIME_BITS-1:0] press_age;
    logic [TIME_BITS-1:0] release_age;
    logic [TIME_BITS-1:0] on_age;
    logic [TIME_BITS-1:0] off_age;
    logic [CMP_W-1:0]     debounce_ext;
    logic [CMP_W-1:0]     idle_ext;
    logic [CMP_W-1:0]     blink_ext;
    logic                 debounced;
    logic                 idle_done;

    assign debounce_ext = CMP_W'(cfg.debounce_ms);
    assign idle_ext     = CMP_W'(cfg.idle_ms);
    assign blink_ext    = CMP_W'(cfg.blink_ms);

    // next state for one poll
    always_comb
    begin
        level_before_next   = button_live_reg ? level_now_reg : level_before_reg;
        press_stamp_next    = press_stamp_reg;
        release_stamp_next  = release_stamp_reg;
        press_total_next    = press_total_reg;
        button_live_next    = button_live_reg;
        lamp_on_next        = lamp_on_reg;
        lamp_on_stamp_next  = lamp_on_stamp_reg;
        lamp_off_stamp_next = lamp_off_stamp_reg;
        toggles_left_next   = toggles_left_reg;
        blink_active_next   = blink_active_reg;

        // edge stamps
        if (!level_before_next && btn)
        begin
            press_stamp_next = now;
        end
        if (level_before_next && !btn)
        begin
            release_stamp_next = now;
        end
        edge_seen_next = edge_seen_reg | (level_before_next != btn);

        // debounced press count
        press_age   = now - press_stamp_next;
        release_age = now - release_stamp_next;
        debounced   = (CMP_W'(press_age) > debounce_ext) &&
                      (CMP_W'(release_age) > debounce_ext);
        if (edge_seen_next && debounced && !btn)
        begin
            if (press_total_next < pcbb_pkg::PRESS_MAX)
            begin
                press_total_next = press_total_next + 1'b1;
            end
            edge_seen_next = 1'b0;
        end

        // start of blinking after the idle time
        idle_done = CMP_W'(release_age) > idle_ext;
        if (idle_done && (press_total_next != '0) && !btn && !level_before_next)
        begin
            button_live_next  = 1'b0;
            blink_active_next = 1'b1;
            toggles_left_next = {press_total_next, 1'b0};
            press_total_next  = '0;
        end

        // lamp toggling
        on_age  = now - lamp_on_stamp_next;
        off_age = '0;
        if (blink_active_next)
        begin
            if (lamp_on_next && (CMP_W'(on_age) > blink_ext))
            begin
                lamp_on_next        = 1'b0;
                lamp_off_stamp_next = now;
                toggles_left_next   = toggles_left_next - 1'b1;
            end
            off_age = now - lamp_off_stamp_next;
            if (!lamp_on_next && (CMP_W'(off_age) > blink_ext))
            begin
                lamp_on_next       = 1'b1;
                lamp_on_stamp_next = now;
                toggles_left_next  = toggles_left_next - 1'b1;
            end
            if (toggles_left_next == '0)
            begin
                blink_active_next = 1'b0;
                button_live_next  = 1'b1;
            end
        end
    end

    // result of this poll
    assign result.red_led         = lamp_on_reg;
    assign result.blue_led        = btn;
    assign result.presses_pending = press_total_next;
    assign result.blinking        = blink_active_next;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_now_reg      <= 1'b0;
            level_before_reg   <= 1'b0;
            edge_seen_reg      <= 1'b0;
            press_stamp_reg    <= '0;
            release_stamp_reg  <= '0;
            press_total_reg    <= '0;
            button_live_reg    <= 1'b1;
            lamp_on_reg        <= 1'b0;
            lamp_on_stamp_reg  <= '0;
            lamp_off_stamp_reg <= '0;
            toggles_left_reg   <= '0;
            blink_active_reg   <= 1'b0;
        end
        else if (step)
        begin
            level_now_reg      <= btn;
            level_before_reg   <= level_before_next;
            edge_seen_reg      <= edge_seen_next;
            press_stamp_reg    <= press_stamp_next;
            release_stamp_reg  <= release_stamp_next;
            press_total_reg    <= press_total_next;
            button_live_reg    <= button_live_next;
            lamp_on_reg        <= lamp_on_next;
            lamp_on_stamp_reg  <= lamp_on_stamp_next;
            lamp_off_stamp_reg <= lamp_off_stamp_next;
            toggles_left_reg   <= toggles_left_next;
            blink_active_reg   <= blink_active_next;
        end
    end

endmodule

// File: hw/rtl/press_count_blink_back.sv
// ----------------------------------------------------------------------------
// press_count_blink_back: debounced press counter with LED blink-back
// Counts debounced button presses from timestamped polls and, once the button
// has been idle, blinks the red LED once per counted press.
//
//   channel  direction  handshake             payload
//   in       to block   in_valid / in_ready   now_ms, button
//   out      from block out_valid / out_ready red_led, blue_led,
//                                             presses_pending, blinking
//   cfg      to block   cfg_write             cfg_index, cfg_data
//
// One request per cycle while the result register is not stalled: a poll is
// held in the input register, its state update and result are formed in the
// core and land in the result register, so throughput is one poll per cycle.
// Reset restores the register defaults and clears all button and LED state.
// A stalled result register holds the input register, which then backpressures.
// ----------------------------------------------------------------------------
module press_count_blink_back
#(
    parameter int TIME_BITS = pcbb_pkg::TIME_BITS_DEFAULT
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [pcbb_pkg::NOW_W-1:0]     now_ms,
    input  logic                           button,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           red_led,
    output logic                           blue_led,
    output logic [pcbb_pkg::COUNT_W-1:0]   presses_pending,
    output logic                           blinking,
    input  logic                           cfg_write,
    input  logic [pcbb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pcbb_pkg::CFG_W-1:0]     cfg_data
);

    localparam int EXT_W = (TIME_BITS > pcbb_pkg::NOW_W) ? TIME_BITS : pcbb_pkg::NOW_W;

    logic                   in_valid_reg;
    logic [TIME_BITS-1:0]   now_reg;
    logic                   button_reg;
    logic                   out_valid_reg;
    pcbb_pkg::result_t      result_reg;
    pcbb_pkg::result_t      result_next;
    pcbb_pkg::cfg_t         cfg;
    logic [EXT_W-1:0]       now_ext;
    logic                   advance;

    // timestamp taken to the internal time width
    assign now_ext = EXT_W'(now_ms);

    // handshake control
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            now_reg    <= now_ext[TIME_BITS-1:0];
            button_reg <= button;
        end
    end

    // timing registers
    pcbb_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // state update
    pcbb_core #(.TIME_BITS(TIME_BITS)) u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .now    (now_reg),
        .btn    (button_reg),
        .cfg    (cfg),
        .result (result_next)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign red_led         = result_reg.red_led;
    assign blue_led        = result_reg.blue_led;
    assign presses_pending = result_reg.presses_pending;
    assign blinking        = result_reg.blinking;

endmodule
